// File: rtl/wwrb_pkg.sv
package wwrb_pkg;

  localparam int WWRB_MAX_WORDS  = 64;
  localparam int WWRB_WIDTH_BITS = 12;

  localparam int WORD_W  = 12;
  localparam int COLS_W  = 12;
  localparam int START_W = 6;
  localparam int END_W   = 7;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic REG_MAX_COLS = 1'b0;
  localparam logic REG_BALANCED = 1'b1;

  typedef struct packed {
    logic [WORD_W-1:0] word_width;
    logic              last_word;
  } word_in_t;

  typedef struct packed {
    logic [START_W-1:0] row_start;
    logic [END_W-1:0]   row_end;
    logic               last_row;
    logic               overflow;
  } row_out_t;

endpackage

// File: rtl/word_wrap_row_breaker.sv
// Word wrap row breaker.
// Load a list of word widths through start_i/word_in_i, one item per cycle while
// busy_o is low; an item is taken at a clock edge with start_i high and busy_o low.
// The item that carries last_word closes the list and raises busy_o.
// The block then splits the list into rows and presents each row on row_o,
// marked by row_valid_o for exactly one cycle; the receiver cannot stall.
// The row with last_row set is the final one; busy_o falls after it.
// A single pass walks the word store through its one read port, one word per cycle,
// through one shared add/compare unit. Zero limit: one row holding the whole list.
// Greedy: one pass, with rows emitted during the pass. Balanced: one counting pass,
// then about log2(total - longest) search passes and one emitting pass.
// Words beyond MAX_WORDS are dropped and overflow is set on every row of that list.
// Reset empties the list and clears max_cols and balanced_mode; the store is
// not cleared. Configure max_cols (byte address 0) and balanced_mode (address 4)
// over the APB port only while busy_o is low.
module word_wrap_row_breaker import wwrb_pkg::*; #(
  parameter int MAX_WORDS  = WWRB_MAX_WORDS,
  parameter int WIDTH_BITS = WWRB_WIDTH_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  word_in_t           word_in_i,
  output logic               row_valid_o,
  output row_out_t           row_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int IW  = $clog2(MAX_WORDS);
  localparam int CW  = $clog2(MAX_WORDS + 1);
  localparam int SW0 = WIDTH_BITS + CW + 1;
  localparam int SW  = (SW0 > COLS_W + 1) ? SW0 : COLS_W + 1;

  localparam logic [CW-1:0] ONE_C = CW'(1);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_WORDS);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DISP   = 3'd1;
  localparam logic [2:0] S_FIRST  = 3'd2;
  localparam logic [2:0] S_RUN    = 3'd3;
  localparam logic [2:0] S_EVAL   = 3'd4;
  localparam logic [2:0] S_SEARCH = 3'd5;
  localparam logic [2:0] S_LAST   = 3'd6;

  logic [2:0]            state_q, state_d;
  logic [COLS_W-1:0]     max_cols_q;
  logic                  balanced_q;
  logic [CW-1:0]         count_q, count_d;
  logic                  dropped_q, dropped_d;
  logic [WIDTH_BITS-1:0] longest_q, longest_d;
  logic [SW-1:0]         joined_q, joined_d;
  logic [SW-1:0]         low_q, low_d;
  logic [SW-1:0]         high_q, high_d;
  logic [CW-1:0]         target_q, target_d;
  logic [SW-1:0]         width_q, width_d;
  logic [SW-1:0]         cur_q, cur_d;
  logic [CW-1:0]         i_q, i_d;
  logic [CW-1:0]         start_q, start_d;
  logic [CW-1:0]         rows_q, rows_d;
  logic                  emit_q, emit_d;
  logic                  search_q, search_d;

  logic [WIDTH_BITS-1:0] mem [MAX_WORDS];
  logic [WIDTH_BITS-1:0] rdata_q;
  logic [IW-1:0]         raddr;
  logic                  wr_en;
  logic [WIDTH_BITS-1:0] w_in;

  logic [SW-1:0]         sum;
  logic [CW-1:0]         i_inc;
  logic [SW-1:0]         lo_init;
  logic [SW-1:0]         hi_init;
  logic [CW-1:0]         out_start;
  logic [CW-1:0]         out_end;
  logic                  out_last;
  logic                  cfg_wr;

  assign w_in   = WIDTH_BITS'(word_in_i.word_width);
  assign busy_o = (state_q != S_IDLE);
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  assign prdata = (paddr[2] == REG_BALANCED) ? PDATA_W'(balanced_q) : PDATA_W'(max_cols_q);

  assign sum     = cur_q + SW'(1) + SW'(rdata_q);
  assign i_inc   = i_q + ONE_C;
  assign lo_init = (longest_q == '0) ? SW'(1) : SW'(longest_q);
  assign hi_init = (joined_q < lo_init) ? lo_init : joined_q;

  always_comb begin
    unique case (state_q)
      S_FIRST: raddr = IW'(1);
      S_RUN:   raddr = IW'(i_inc);
      default: raddr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[count_q[IW-1:0]] <= w_in;
    end
    rdata_q <= mem[raddr];
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    dropped_d = dropped_q;
    longest_d = longest_q;
    joined_d  = joined_q;
    low_d     = low_q;
    high_d    = high_q;
    target_d  = target_q;
    width_d   = width_q;
    cur_d     = cur_q;
    i_d       = i_q;
    start_d   = start_q;
    rows_d    = rows_q;
    emit_d    = emit_q;
    search_d  = search_q;
    wr_en     = 1'b0;
    out_start = start_q;
    out_end   = count_q;
    out_last  = 1'b0;
    row_valid_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (count_q < MAX_C) begin
            wr_en    = 1'b1;
            count_d  = count_q + ONE_C;
            joined_d = joined_q + SW'(w_in) + SW'(count_q != '0);
            if (w_in > longest_q) begin
              longest_d = w_in;
            end
          end else begin
            dropped_d = 1'b1;
          end
          if (word_in_i.last_word) begin
            state_d = S_DISP;
          end
        end
      end
      S_DISP: begin
        start_d = '0;
        if (max_cols_q == '0) begin
          state_d = S_LAST;
        end else begin
          width_d  = SW'(max_cols_q);
          emit_d   = !balanced_q;
          search_d = 1'b0;
          state_d  = S_FIRST;
        end
      end
      S_FIRST: begin
        cur_d   = SW'(rdata_q);
        start_d = '0;
        rows_d  = ONE_C;
        i_d     = ONE_C;
        if (count_q == ONE_C) begin
          state_d = emit_q ? S_LAST : S_EVAL;
        end else begin
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        if (sum <= width_q) begin
          cur_d = sum;
        end else begin
          rows_d  = rows_q + ONE_C;
          cur_d   = SW'(rdata_q);
          start_d = i_q;
          if (emit_q) begin
            row_valid_o = 1'b1;
            out_start   = start_q;
            out_end     = i_q;
          end
        end
        i_d = i_inc;
        if (i_inc == count_q) begin
          state_d = emit_q ? S_LAST : S_EVAL;
        end
      end
      S_EVAL: begin
        if (!search_q) begin
          target_d = rows_q;
          if (rows_q <= ONE_C) begin
            start_d = '0;
            state_d = S_LAST;
          end else begin
            low_d    = lo_init;
            high_d   = hi_init;
            search_d = 1'b1;
            state_d  = S_SEARCH;
          end
        end else begin
          if (rows_q <= target_q) begin
            high_d = width_q;
          end else begin
            low_d = width_q + SW'(1);
          end
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (low_q < high_q) begin
          width_d = low_q + ((high_q - low_q) >> 1);
          emit_d  = 1'b0;
        end else begin
          width_d = low_q;
          emit_d  = 1'b1;
        end
        state_d = S_FIRST;
      end
      S_LAST: begin
        row_valid_o = 1'b1;
        out_start   = start_q;
        out_end     = count_q;
        out_last    = 1'b1;
        count_d     = '0;
        dropped_d   = 1'b0;
        longest_d   = '0;
        joined_d    = '0;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign row_o.row_start = START_W'(out_start);
  assign row_o.row_end   = END_W'(out_end);
  assign row_o.last_row  = out_last;
  assign row_o.overflow  = dropped_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      max_cols_q <= '0;
      balanced_q <= 1'b0;
      count_q    <= '0;
      dropped_q  <= 1'b0;
      longest_q  <= '0;
      joined_q   <= '0;
      emit_q     <= 1'b0;
      search_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      dropped_q <= dropped_d;
      longest_q <= longest_d;
      joined_q  <= joined_d;
      emit_q    <= emit_d;
      search_q  <= search_d;
      if (cfg_wr) begin
        if (paddr[2] == REG_MAX_COLS) begin
          max_cols_q <= pwdata[COLS_W-1:0];
        end else begin
          balanced_q <= pwdata[0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    low_q    <= low_d;
    high_q   <= high_d;
    target_q <= target_d;
    width_q  <= width_d;
    cur_q    <= cur_d;
    i_q      <= i_d;
    start_q  <= start_d;
    rows_q   <= rows_d;
  end

endmodule

// File: rtl/wwrb_checker.sv
module wwrb_checker import wwrb_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start_i,
  input logic     busy_o,
  input word_in_t word_in_i,
  input logic     row_valid_o,
  input row_out_t row_o
);

  a_row_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_valid_o |-> busy_o)
    else $error("row strobe while idle");

  a_last_word_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && word_in_i.last_word) |=> busy_o)
    else $error("list close did not raise busy");

  a_mid_word_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !word_in_i.last_word) |=> !busy_o)
    else $error("non-final item raised busy");

  a_last_row_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_valid_o && row_o.last_row) |=> (!busy_o && !row_valid_o))
    else $error("activity after final row");

endmodule

bind word_wrap_row_breaker wwrb_checker u_wwrb_checker (.*);

// File: tb/sv/word_wrap_row_breaker_tb.sv
module word_wrap_row_breaker_tb
  import wwrb_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT = 20000;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  word_in_t           word_in_i;
  logic               row_valid_o;
  row_out_t           row_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  logic [WORD_W-1:0] stored_widths [WWRB_MAX_WORDS];
  int unsigned       held_words   = 0;
  int unsigned       longest      = 0;
  int unsigned       joined_len   = 0;
  logic              list_dropped = 1'b0;
  logic [COLS_W-1:0] cols_limit   = '0;
  logic              balanced     = 1'b0;
  row_out_t          pending_rows [$];

  int unsigned words_sent   = 0;
  int unsigned quiet_cycles = 0;
  int          errors       = 0;
  bit          gaps_on      = 1'b1;

  word_wrap_row_breaker dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned fit_row_count(int unsigned lim);
    int unsigned rows;
    int unsigned run;
    rows = 1;
    run  = stored_widths[0];
    for (int unsigned i = 1; i < held_words; i++) begin
      if (run + 1 + stored_widths[i] <= lim) begin
        run += 1 + stored_widths[i];
      end else begin
        rows++;
        run = stored_widths[i];
      end
    end
    return rows;
  endfunction

  function automatic void push_row(int unsigned first, int unsigned stop, logic last);
    row_out_t r;
    r.row_start = START_W'(first);
    r.row_end   = END_W'(stop);
    r.last_row  = last;
    r.overflow  = list_dropped;
    pending_rows.push_back(r);
  endfunction

  function automatic void push_fitted_rows(int unsigned lim);
    int unsigned run;
    int unsigned first;
    run   = stored_widths[0];
    first = 0;
    for (int unsigned i = 1; i < held_words; i++) begin
      if (run + 1 + stored_widths[i] <= lim) begin
        run += 1 + stored_widths[i];
      end else begin
        push_row(first, i, 1'b0);
        first = i;
        run   = stored_widths[i];
      end
    end
    push_row(first, held_words, 1'b1);
  endfunction

  function automatic void take_word(word_in_t item);
    int unsigned target;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    if (held_words < WWRB_MAX_WORDS) begin
      stored_widths[held_words] = item.word_width;
      joined_len += item.word_width + (held_words > 0 ? 1 : 0);
      if (item.word_width > longest) begin
        longest = item.word_width;
      end
      held_words++;
    end else begin
      list_dropped = 1'b1;
    end
    if (!item.last_word) begin
      return;
    end
    if (cols_limit == 0) begin
      push_row(0, held_words, 1'b1);
    end else if (!balanced) begin
      push_fitted_rows(cols_limit);
    end else begin
      target = fit_row_count(cols_limit);
      if (target <= 1) begin
        push_row(0, held_words, 1'b1);
      end else begin
        lo = (longest == 0) ? 1 : longest;
        hi = (joined_len < lo) ? lo : joined_len;
        while (lo < hi) begin
          mid = lo + (hi - lo) / 2;
          if (fit_row_count(mid) <= target) begin
            hi = mid;
          end else begin
            lo = mid + 1;
          end
        end
        push_fitted_rows(lo);
      end
    end
    held_words   = 0;
    longest      = 0;
    joined_len   = 0;
    list_dropped = 1'b0;
  endfunction

  always @(posedge clk_i) begin
    row_out_t want;
    if (rst_ni && row_valid_o) begin
      if (pending_rows.size() == 0) begin
        $error("unexpected row: start %0d end %0d", row_o.row_start, row_o.row_end);
        errors++;
      end else begin
        want = pending_rows.pop_front();
        if (row_o.row_start !== want.row_start) begin
          $error("row_start: expected %0d, got %0d", want.row_start, row_o.row_start);
          errors++;
        end
        if (row_o.row_end !== want.row_end) begin
          $error("row_end: expected %0d, got %0d", want.row_end, row_o.row_end);
          errors++;
        end
        if (row_o.last_row !== want.last_row) begin
          $error("last_row: expected %0d, got %0d", want.last_row, row_o.last_row);
          errors++;
        end
        if (row_o.overflow !== want.overflow) begin
          $error("overflow: expected %0d, got %0d", want.overflow, row_o.overflow);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || row_valid_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(input logic [WORD_W-1:0] w, input logic last);
    word_in_t item;
    item.word_width = w;
    item.last_word  = last;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    start_i   <= 1'b1;
    word_in_i <= item;
    do @(posedge clk_i); while (busy_o);
    take_word(item);
    words_sent++;
  endtask

  task automatic send_words(input int unsigned ws[$]);
    foreach (ws[i]) begin
      send_word(WORD_W'(ws[i]), i == ws.size() - 1);
    end
  endtask

  task automatic send_random_list(input int unsigned n, input int unsigned wmax);
    for (int unsigned i = 0; i < n; i++) begin
      send_word(WORD_W'($urandom_range(0, wmax)), i == n - 1);
    end
  endtask

  task automatic drain_rows();
    start_i <= 1'b0;
    while (pending_rows.size() != 0 || busy_o) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                            input logic [PDATA_W-1:0] data, output logic [PDATA_W-1:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
  endtask

  task automatic set_config(input logic [COLS_W-1:0] cols, input logic bal);
    logic [PDATA_W-1:0] rd;
    drain_rows();
    apb_access(1'b1, {REG_MAX_COLS, 2'b00}, PDATA_W'(cols), rd);
    apb_access(1'b1, {REG_BALANCED, 2'b00}, PDATA_W'(bal), rd);
    cols_limit = cols;
    balanced   = bal;
    apb_access(1'b0, {REG_MAX_COLS, 2'b00}, '0, rd);
    if (rd !== PDATA_W'(cols)) begin
      $error("max_cols: expected %0d, got %0d", cols, rd);
      errors++;
    end
    apb_access(1'b0, {REG_BALANCED, 2'b00}, '0, rd);
    if (rd !== PDATA_W'(bal)) begin
      $error("balanced_mode: expected %0d, got %0d", bal, rd);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic test_zero_limit();
    send_words('{4095, 0, 17});
    send_words('{5});
    set_config(0, 1'b1);
    send_words('{4095, 4095});
  endtask

  task automatic test_greedy_edges();
    set_config(10, 1'b0);
    send_words('{3, 4, 2, 12, 0, 5, 10});
    set_config(4095, 1'b0);
    send_words('{4095, 4095, 1});
  endtask

  task automatic test_balanced_edges();
    set_config(10, 1'b1);
    send_words('{3, 4, 2, 5, 6, 1});
    set_config(1, 1'b1);
    send_words('{0, 0, 0, 0});
    set_config(4095, 1'b1);
    send_words('{2, 3});
  endtask

  task automatic test_store_full();
    set_config(12, 1'b0);
    send_random_list(65, 7);
    set_config(4095, 1'b1);
    send_random_list(66, 4095);
  endtask

  task automatic test_random_traffic(input int unsigned budget, input bit idle);
    logic [COLS_W-1:0] cols;
    int unsigned       len;
    int unsigned       wmax;
    int unsigned       pick;
    while (words_sent < budget) begin
      case ($urandom_range(0, 4))
        0:       cols = 0;
        1:       cols = 1;
        2:       cols = 4095;
        3:       cols = COLS_W'($urandom_range(1, 80));
        default: cols = COLS_W'($urandom_range(1, 4095));
      endcase
      set_config(cols, 1'($urandom_range(0, 1)));
      gaps_on = idle && ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 4)) begin
        pick = $urandom_range(0, 19);
        if (pick < 14) begin
          len = $urandom_range(1, 8);
        end else if (pick < 19) begin
          len = $urandom_range(9, 24);
        end else begin
          len = $urandom_range(40, 64);
        end
        case ($urandom_range(0, 2))
          0:       wmax = 7;
          1:       wmax = 63;
          default: wmax = 4095;
        endcase
        send_random_list(len, wmax);
      end
    end
  endtask

  initial begin
    rst_ni    <= 1'b0;
    start_i   <= 1'b0;
    word_in_i <= '0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_zero_limit();
    test_greedy_edges();
    test_balanced_edges();
    test_store_full();
    test_random_traffic(215, 1'b1);
    test_random_traffic(265, 1'b0);
    drain_rows();
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
